/* src/ksbm_pkg.sv */
// Shared payload types for the k-sorted block merge sorter.
package ksbm_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned WINDOW_W = 6;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd32;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_value;
    } out_item_t;

endpackage

/* src/k_sorted_block_merge_sorter_core.sv */
// Top level of the k-sorted block merge sorter.
// Each item is taken from the queue and inserted, then a decide step follows.
// A merge then emits one value per cycle while the receiver takes results, and retains
// the rest at one per cycle; a closing step then makes the retained values the held
// block.
// Reset (rst_n low, asynchronous) empties the input queue, the result register and
// the stores; window = 32.
module k_sorted_block_merge_sorter_core #(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    input  ksbm_pkg::in_item_t  in_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output ksbm_pkg::out_item_t out_item
);

    localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

    // hand-off between the input queue and the merge engine
    logic               q_valid;
    ksbm_pkg::in_item_t q_item;
    logic               q_take;
    logic [CW-1:0]      k_value;

    assign pready = 1'b1;

    // Front: hold the window register and queue accepted transfers.
    ksbm_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .CW         (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .push      (push),
        .push_item (in_item),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_take    (q_take),
        .k_value   (k_value)
    );

    // Back: insert into the sorted block, merge with the held block, drive results.
    ksbm_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .CW         (CW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take),
        .k_value  (k_value),
        .empty    (empty),
        .pop_item (out_item),
        .pop      (pop)
    );

endmodule

/* src/ksbm_front.sv */
// Front end: configuration register, window clamp and input item queue.
module ksbm_front #(
    parameter int unsigned MAX_WINDOW = 32,
    parameter int unsigned CW = $clog2(MAX_WINDOW + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    input  logic                push,
    input  ksbm_pkg::in_item_t  push_item,
    output logic                full,
    output logic                q_valid,
    output ksbm_pkg::in_item_t  q_item,
    input  logic                q_take,
    output logic [CW-1:0]       k_value
);

    localparam int unsigned QD = ksbm_pkg::QUEUE_DEPTH;
    localparam int unsigned PW = $clog2(QD);

    logic [ksbm_pkg::WINDOW_W-1:0] window_reg;
    ksbm_pkg::in_item_t            q_mem [QD];
    logic [PW-1:0]                 wr_ptr_reg;
    logic [PW-1:0]                 rd_ptr_reg;
    logic [PW:0]                   cnt_reg;
    logic                          do_push;
    logic                          do_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= ksbm_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite && (paddr == 3'd0))
        begin
            window_reg <= pwdata[ksbm_pkg::WINDOW_W-1:0];
        end
    end

    assign prdata = (paddr == 3'd0) ? {26'd0, window_reg} : 32'd0;

    // clamp the window to 1..MAX_WINDOW
    always_comb
    begin
        if (window_reg == '0)
        begin
            k_value = CW'(1);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            k_value = CW'(MAX_WINDOW);
        end
        else
        begin
            k_value = CW'(window_reg);
        end
    end

    assign full    = (cnt_reg == (PW+1)'(QD));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (PW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - (PW+1)'(1);
            end
        end
    end

endmodule

/* src/ksbm_back.sv */
// Back end: sorted block insertion, block/held merge and result register.
module ksbm_back #(
    parameter int unsigned MAX_WINDOW = 32,
    parameter int unsigned CW = $clog2(MAX_WINDOW + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ksbm_pkg::in_item_t  q_item,
    output logic                q_take,
    input  logic [CW-1:0]       k_value,
    output logic                empty,
    output ksbm_pkg::out_item_t pop_item,
    input  logic                pop
);

    localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_MERGE  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic signed [31:0]         blk_reg  [MAX_WINDOW];
    logic signed [31:0]         blk_next [MAX_WINDOW];
    logic signed [31:0]         held_reg  [MAX_WINDOW];
    logic signed [31:0]         held_next [MAX_WINDOW];
    logic [CW-1:0]              bcnt_reg, bcnt_next;
    logic [CW-1:0]              hcnt_reg, hcnt_next;
    logic [CW-1:0]              app_reg, app_next;
    logic [CW:0]                rem_reg, rem_next;
    logic                       last_reg, last_next;
    logic                       first_reg, first_next;
    logic                       ov_reg, ov_next;
    ksbm_pkg::out_item_t        oitem_reg, oitem_next;

    logic [MAX_WINDOW-1:0]      keep;
    logic [CW:0]                total;
    logic [CW:0]                emit;
    logic                       take_blk;
    logic signed [31:0]         head_val;
    logic [CW-1:0]              widx;
    logic                       oslot;

    assign q_take   = (state_reg == S_IDLE) && q_valid;
    assign empty    = !ov_reg;
    assign pop_item = oitem_reg;
    assign oslot    = !ov_reg || pop;
    assign total    = {1'b0, bcnt_reg} + {1'b0, hcnt_reg};
    assign take_blk = (bcnt_reg != '0) &&
                      ((hcnt_reg == '0) || (blk_reg[0] <= held_reg[0]));
    assign head_val = take_blk ? blk_reg[0] : held_reg[0];
    assign widx     = hcnt_reg - (take_blk ? CW'(0) : CW'(1)) + app_reg;

    // entries at or below the new value stay in place
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            keep[i] = (CW'(i) < bcnt_reg) && (blk_reg[i] <= q_item.sample_value);
        end
    end

    always_comb
    begin
        emit = {1'b0, k_value};
        if ((total > (CW+1)'(MAX_WINDOW)) &&
            (total - (CW+1)'(MAX_WINDOW) > {1'b0, k_value}))
        begin
            emit = total - (CW+1)'(MAX_WINDOW);
        end
        if (emit > total)
        begin
            emit = total;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        held_next  = held_reg;
        bcnt_next  = bcnt_reg;
        hcnt_next  = hcnt_reg;
        app_next   = app_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        first_next = first_reg;
        ov_next    = ov_reg && !pop;
        oitem_next = oitem_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    last_next = q_item.end_of_stream;
                    if (bcnt_reg < CW'(MAX_WINDOW))
                    begin
                        blk_next[0] = keep[0] ? blk_reg[0] : q_item.sample_value;
                        for (int i = 1; i < MAX_WINDOW; i++)
                        begin
                            if (keep[i])
                            begin
                                blk_next[i] = blk_reg[i];
                            end
                            else if (keep[i-1])
                            begin
                                blk_next[i] = q_item.sample_value;
                            end
                            else
                            begin
                                blk_next[i] = blk_reg[i-1];
                            end
                        end
                        bcnt_next = bcnt_reg + CW'(1);
                    end
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (last_reg)
                begin
                    rem_next   = total;
                    app_next   = '0;
                    state_next = S_MERGE;
                end
                else if (bcnt_reg < k_value)
                begin
                    state_next = S_IDLE;
                end
                else if (first_reg)
                begin
                    held_next  = blk_reg;
                    hcnt_next  = bcnt_reg;
                    bcnt_next  = '0;
                    first_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rem_next   = emit;
                    app_next   = '0;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if ((bcnt_reg == '0) && (hcnt_reg == '0))
                begin
                    // retained values now form the held block
                    hcnt_next = app_reg;
                    app_next  = '0;
                    if (last_reg)
                    begin
                        first_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if ((rem_reg == '0) || oslot)
                begin
                    if (take_blk)
                    begin
                        for (int i = 0; i < MAX_WINDOW - 1; i++)
                        begin
                            blk_next[i] = blk_reg[i+1];
                        end
                        bcnt_next = bcnt_reg - CW'(1);
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_WINDOW - 1; i++)
                        begin
                            held_next[i] = held_reg[i+1];
                        end
                        hcnt_next = hcnt_reg - CW'(1);
                    end
                    if (rem_reg != '0)
                    begin
                        ov_next                 = 1'b1;
                        oitem_next.sorted_value = head_val;
                        oitem_next.final_value  = last_reg && (rem_reg == (CW+1)'(1));
                        rem_next                = rem_reg - (CW+1)'(1);
                    end
                    else
                    begin
                        held_next[widx[IW-1:0]] = head_val;
                        app_next                = app_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        blk_reg   <= blk_next;
        held_reg  <= held_next;
        oitem_reg <= oitem_next;
        app_reg   <= app_next;
        rem_reg   <= rem_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bcnt_reg  <= '0;
            hcnt_reg  <= '0;
            first_reg <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
            hcnt_reg  <= hcnt_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

/* bench/k_sorted_block_merge_sorter_core_tb.sv */
// Self-checking testbench for the k-sorted block merge sorter core.
`timescale 1ns / 1ps

module k_sorted_block_merge_sorter_core_tb;

    localparam int MAX_K = 32;
    localparam logic [2:0] ADDR_WINDOW = 3'd0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    ksbm_pkg::in_item_t in_item = '0;
    logic full, empty;
    logic pop = 1'b0;
    ksbm_pkg::out_item_t out_item;

    // Sorter shadow state
    logic [31:0] held_vals[MAX_K];
    int          held_num;
    logic [31:0] blk_vals[MAX_K];
    int          blk_num;
    bit          first_pending;
    logic [5:0]  window_reg;
    ksbm_pkg::out_item_t sorted_expect[$];

    int  errors = 0;
    bit  hold_off = 1'b0;       // receiver held off by the pressure phase
    int  hold_cycles = 0;

    always #5 clk = ~clk;

    k_sorted_block_merge_sorter_core dut (.*);

    // Signed ascending compare via flipped sign bit
    function automatic bit le_signed(logic [31:0] a, logic [31:0] b);
        return (a ^ 32'h8000_0000) <= (b ^ 32'h8000_0000);
    endfunction

    function automatic void shadow_reset();
        held_num = 0;
        blk_num = 0;
        first_pending = 1'b1;
        window_reg = ksbm_pkg::WINDOW_RESET;
    endfunction

    // Predict the outputs caused by one accepted item
    function automatic void sorter_predict(ksbm_pkg::in_item_t it);
        logic [31:0] mrg[2*MAX_K];
        int k, i, j, n, emit;
        ksbm_pkg::out_item_t o;
        k = (window_reg < 1) ? 1 : ((window_reg > MAX_K) ? MAX_K : int'(window_reg));
        if (blk_num < MAX_K)
        begin
            i = blk_num;
            while (i > 0 && !le_signed(blk_vals[i-1], it.sample_value))
            begin
                blk_vals[i] = blk_vals[i-1];
                i--;
            end
            blk_vals[i] = it.sample_value;
            blk_num++;
        end
        if (!it.end_of_stream && blk_num < k) return;
        if (!it.end_of_stream && first_pending)
        begin
            for (i = 0; i < blk_num; i++) held_vals[i] = blk_vals[i];
            held_num = blk_num;
            blk_num = 0;
            first_pending = 1'b0;
            return;
        end
        // Merge: on a tie the block value goes first
        i = 0; j = 0; n = 0;
        while (i < blk_num && j < held_num)
        begin
            if (le_signed(blk_vals[i], held_vals[j])) mrg[n++] = blk_vals[i++];
            else mrg[n++] = held_vals[j++];
        end
        while (i < blk_num) mrg[n++] = blk_vals[i++];
        while (j < held_num) mrg[n++] = held_vals[j++];
        if (it.end_of_stream)
        begin
            for (i = 0; i < n; i++)
            begin
                o.sorted_value = mrg[i];
                o.final_value = (i == n - 1);
                sorted_expect.insert(sorted_expect.size(), o);
            end
            held_num = 0;
            blk_num = 0;
            first_pending = 1'b1;
            return;
        end
        emit = k;
        if (n - MAX_K > emit) emit = n - MAX_K;
        if (emit > n) emit = n;
        for (i = 0; i < emit; i++)
        begin
            o.sorted_value = mrg[i];
            o.final_value = 1'b0;
            sorted_expect.insert(sorted_expect.size(), o);
        end
        held_num = n - emit;
        for (i = 0; i < held_num; i++) held_vals[i] = mrg[emit + i];
        blk_num = 0;
    endfunction

    // Receiver: random pop gaps, plus the long hold-off when requested
    int rx_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (sorted_expect.size() == 0)
                begin
                    $display("%0t: unexpected output value %0d final %0b",
                             $time, out_item.sorted_value, out_item.final_value);
                    errors++;
                end
                else
                begin
                    if (out_item.sorted_value !== sorted_expect[0].sorted_value)
                    begin
                        $display("%0t: sorted_value expected %0d actual %0d", $time,
                                 sorted_expect[0].sorted_value, out_item.sorted_value);
                        errors++;
                    end
                    if (out_item.final_value !== sorted_expect[0].final_value)
                    begin
                        $display("%0t: final_value expected %0b actual %0b", $time,
                                 sorted_expect[0].final_value, out_item.final_value);
                        errors++;
                    end
                    void'(sorted_expect.pop_front());
                end
            end
            if (hold_off)
            begin
                pop <= 1'b0;
            end
            else if (pop && !empty)
            begin
                rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                pop <= (rx_gap == 0);
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= (rx_gap == 0);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Long receiver stall counted in its own process
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1) hold_off <= 1'b0;
        end
    end

    int max_tx_gap = 12;

    // Send one item; predict on the accepting edge; push stays high for a
    // back-to-back follower and drops before any idle gap
    task automatic send_item(logic [31:0] val, bit last);
        int gap;
        gap = (max_tx_gap == 0 || $urandom_range(0, 3) == 0) ? 0
              : $urandom_range(0, max_tx_gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{sample_value: val, end_of_stream: last};
        @(posedge clk);
        while (full) @(posedge clk);
        sorter_predict('{sample_value: val, end_of_stream: last});
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sorted_expect.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_window(logic [5:0] k);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_WINDOW; pwdata <= {26'd0, k};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        window_reg = k;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // One k-sorted stream: sorted base plus a shuffle within blocks of k
    task automatic send_stream(int len, int span, bit noisy);
        logic [31:0] vals[$];
        logic [31:0] t;
        int base, i, a, b, k;
        k = (window_reg < 1) ? 1 : ((window_reg > MAX_K) ? MAX_K : int'(window_reg));
        base = $urandom_range(0, 1) ? -span : $urandom();
        for (i = 0; i < len; i++)
        begin
            vals.insert(vals.size(), base);
            base += $urandom_range(0, 5);
        end
        for (i = 0; i + k <= len; i += k)
        begin
            repeat (k)
            begin
                a = i + $urandom_range(0, k - 1);
                b = i + $urandom_range(0, k - 1);
                t = vals[a]; vals[a] = vals[b]; vals[b] = t;
            end
        end
        if (noisy) vals[$urandom_range(0, len - 1)] = $urandom();
        for (i = 0; i < len; i++) send_item(vals[i], i == len - 1);
    endtask

    task automatic test_directed();
        // Extremes, ties, empty held store, window limits
        write_window(6'd4);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h5555_AAAA, 1'b1);
        drain();
        send_item(32'h1234, 1'b1);       // lone last item
        drain();
        write_window(6'd0);              // acts as one
        send_item(32'd3, 1'b0);
        send_item(32'd2, 1'b0);
        send_item(32'd2, 1'b1);
        drain();
        write_window(6'd63);             // acts as the maximum
        send_stream(70, 100, 1'b0);
        drain();
        write_window(6'd2);
        send_item(32'd10, 1'b0);
        send_item(32'd9, 1'b0);
        drain();
        write_window(6'd32);             // change mid-stream: overflow case
        send_stream(40, 50, 1'b0);
        drain();
    endtask

    task automatic test_random();
        int sent;
        logic [5:0] ks[5] = '{6'd1, 6'd3, 6'd8, 6'd17, 6'd32};
        sent = 0;
        while (sent < 240)
        begin
            write_window(ks[$urandom_range(0, 4)]);
            repeat (3)
            begin
                int len;
                len = $urandom_range(1, 40);
                send_stream(len, $urandom_range(1, 1000), $urandom_range(0, 4) == 0);
                sent += len;
            end
            drain();
        end
    endtask

    task automatic test_pressure();
        // Receiver stalls long while the sender keeps pushing
        write_window(6'd5);
        max_tx_gap = 0;
        hold_off <= 1'b1;
        hold_cycles <= 400;
        send_stream(60, 200, 1'b0);
        max_tx_gap = 12;
        drain();
        // Sender pauses until every expected result has come
        send_stream(12, 200, 1'b0);
        drain();
    endtask

    initial
    begin
        shadow_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pressure();
        test_random();
        drain();
        if (errors == 0 && sorted_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
src/ksbm_pkg.sv
src/ksbm_front.sv
src/ksbm_back.sv
src/k_sorted_block_merge_sorter_core.sv
bench/k_sorted_block_merge_sorter_core_tb.sv
